### hw/rtl/hmap_pkg.sv
// shared codes and constants of the heightmap sampler
`timescale 1ns / 1ps

package hmap_pkg;

   // request codes
   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_HEIGHT = 2'd1,
      REQ_NORMAL = 2'd2
   } req_kind_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_MAP_WIDTH    = 2'd0,
      CSR_MAP_HEIGHT   = 2'd1,
      CSR_HEIGHT_SCALE = 2'd2
   } csr_reg_type;

   localparam int SAMPLE_W    = 16;
   localparam int COORD_W     = 18;
   localparam int HEIGHT_W    = 26;
   localparam int NORM_W      = 16;
   localparam int NORM_FRAC   = 14;
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = NORM_FRAC + 1;
   // accept edge to result transfer edge
   localparam int LATENCY     = 8 + SQRT_STAGES + DIV_STAGES;

   localparam logic [15:0] SCALE_DEN = 16'd65280;
   localparam logic [15:0] NORM_ONE  = 16'd16384;

endpackage

### hw/rtl/heightmap_sampler_top.sv
// heightmap store with triangle-aware height and normal queries
`timescale 1ns / 1ps

// channel   handshake                 payload
// request   start / busy              req_type req_col req_row req_sample
//                                     req_coord_x req_coord_z
// result    rsp_valid (strobe)        rsp_height rsp_normal_x/y/z rsp_outside
// config    csr_valid / csr_ready     csr_index csr_wdata
//
// one item per cycle; busy stays low, csr_ready stays high
// a query result shows up after its transfer has passed through the pipeline,
// which holds the 32-step square root and the 15-step divider stages
// a write lands in both sample memories at its own transfer edge
// reset is synchronous and clears the pipeline valids and the configuration registers;
// the sample memories are not cleared and the receiver cannot stall
module heightmap_sampler_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_col,
   input  logic [7:0]         req_row,
   input  logic [15:0]        req_sample,
   input  logic signed [17:0] req_coord_x,
   input  logic signed [17:0] req_coord_z,
   output logic               rsp_valid,
   output logic signed [25:0] rsp_height,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic signed [15:0] rsp_normal_z,
   output logic               rsp_outside,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int WCAP  = MAX_WIDTH > 511 ? 511 : MAX_WIDTH;
   localparam int HCAP  = MAX_HEIGHT > 511 ? 511 : MAX_HEIGHT;
   localparam int TAGS  = hmap_pkg::LATENCY - 1;
   localparam int SQ_W  = 2 * hmap_pkg::SQRT_STAGES;
   localparam int RT_W  = hmap_pkg::SQRT_STAGES;
   localparam int DQ_W  = hmap_pkg::DIV_STAGES;
   localparam int DR_W  = RT_W + DQ_W;

   typedef struct packed {
      logic        valid;
      logic        is_norm;
      logic        outside;
      logic [7:0]  fx;
      logic [7:0]  fz;
      logic        zodd;
      logic [25:0] height;
   } tag_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [RT_W-1:0] root;
      logic [30:0]     am;
      logic [30:0]     bm;
      logic [15:0]     dm;
      logic            an;
      logic            bn;
   } sq_type;

   typedef struct packed {
      logic [DR_W-1:0] rx;
      logic [DR_W-1:0] ry;
      logic [DR_W-1:0] rz;
      logic [DQ_W-1:0] qx;
      logic [DQ_W-1:0] qy;
      logic [DQ_W-1:0] qz;
      logic [RT_W-1:0] len;
      logic            an;
      logic            bn;
   } dv_type;

   function automatic logic [AW-1:0] cell_addr(input logic [8:0] x, input logic [8:0] z);
      return AW'(z) * AW'(MAX_WIDTH) + AW'(x);
   endfunction

   function automatic logic signed [17:0] ext(input logic [15:0] v);
      return $signed({2'b00, v});
   endfunction

   // configuration registers
   logic [8:0]  map_width_ff, map_height_ff;
   logic [15:0] height_scale_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff    <= 9'd256;
         map_height_ff   <= 9'd256;
         height_scale_ff <= 16'd256;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hmap_pkg::CSR_MAP_WIDTH:    map_width_ff    <= csr_wdata[8:0];
            hmap_pkg::CSR_MAP_HEIGHT:   map_height_ff   <= csr_wdata[8:0];
            hmap_pkg::CSR_HEIGHT_SCALE: height_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective map size
   logic [8:0] w, h;

   always_comb begin
      if (map_width_ff < 9'd2) w = 9'd2;
      else if (32'(map_width_ff) > WCAP) w = 9'(WCAP);
      else w = map_width_ff;
      if (map_height_ff < 9'd2) h = 9'd2;
      else if (32'(map_height_ff) > HCAP) h = 9'(HCAP);
      else h = map_height_ff;
   end

   // request decode and read addresses
   logic          acc, is_h, is_n, wr_en;
   logic [8:0]    xh, zh, xi, zi, x1, z1, xn, zn, xq, zq, xs, zs, srow;
   logic          out_h, out_n, negx_bad, negz_bad;
   logic [AW-1:0] wr_addr, ra0, ra1, rb0, rb1;
   tag_type       tag_in;
   tag_type       tag_ff [0:TAGS-1];

   always_comb begin
      acc  = start && !busy;
      is_h = acc && (req_type == hmap_pkg::REQ_HEIGHT);
      is_n = acc && (req_type == hmap_pkg::REQ_NORMAL);

      // write with the row flipped
      srow    = h - 9'd1 - {1'b0, req_row};
      wr_en   = acc && (req_type == hmap_pkg::REQ_WRITE) &&
                ({1'b0, req_col} < w) && ({1'b0, req_row} < h);
      wr_addr = cell_addr({1'b0, req_col}, srow);

      // height query cell, floor of the position
      xh    = req_coord_x[16:8];
      zh    = req_coord_z[16:8];
      out_h = req_coord_x[17] || req_coord_z[17] || (xh >= w) || (zh >= h);
      x1    = ({1'b0, xh} + 10'd1 < {1'b0, w}) ? xh + 9'd1 : w - 9'd1;
      z1    = ({1'b0, zh} + 10'd1 < {1'b0, h}) ? zh + 9'd1 : h - 9'd1;

      // normal query cell, truncation toward zero
      negx_bad = req_coord_x[17] &&
                 !((req_coord_x[17:8] == 10'h3FF) && (req_coord_x[7:0] != 8'd0));
      negz_bad = req_coord_z[17] &&
                 !((req_coord_z[17:8] == 10'h3FF) && (req_coord_z[7:0] != 8'd0));
      xi    = req_coord_x[17] ? 9'd0 : req_coord_x[16:8];
      zi    = req_coord_z[17] ? 9'd0 : req_coord_z[16:8];
      out_n = negx_bad || negz_bad || (xi >= w) || (zi >= h);
      xn    = (xi < w - 9'd1) ? xi + 9'd1 : xi - 9'd1;
      zn    = (zi < h - 9'd1) ? zi + 9'd1 : zi - 9'd1;

      xq = is_n ? xi : xh;
      zq = is_n ? zi : zh;
      xs = is_n ? xn : x1;
      zs = is_n ? zn : z1;

      ra0 = cell_addr(xq, zq);
      ra1 = cell_addr(xs, zq);
      rb0 = cell_addr(xq, zs);
      rb1 = cell_addr(x1, zs);

      tag_in         = '0;
      tag_in.valid   = is_h || is_n;
      tag_in.is_norm = is_n;
      tag_in.outside = is_n ? out_n : out_h;
      tag_in.fx      = req_coord_x[7:0];
      tag_in.fz      = req_coord_z[7:0];
      tag_in.zodd    = zh[0];
   end

   // two copies of the sample store, each with two read ports
   logic [15:0] mem_a [0:DEPTH-1];
   logic [15:0] mem_b [0:DEPTH-1];
   logic [15:0] rd_a0_ff, rd_a1_ff, rd_b0_ff, rd_b1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_a[wr_addr] <= req_sample;
      rd_a0_ff <= mem_a[ra0];
      rd_a1_ff <= mem_a[ra1];
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_b[wr_addr] <= req_sample;
      rd_b0_ff <= mem_b[rb0];
      rd_b1_ff <= mem_b[rb1];
   end

   // rebuild the corner opposite the triangle, and neighbor differences
   logic signed [17:0] c_bl, c_br, c_tl, c_tr;
   logic signed [17:0] bl_ff, br_ff, tl_ff, tr_ff;
   logic signed [16:0] dx_in, dz_in, dx_ff, dz_ff;

   always_comb begin
      c_bl = ext(rd_a0_ff);
      c_br = ext(rd_a1_ff);
      c_tl = ext(rd_b0_ff);
      c_tr = ext(rd_b1_ff);
      if (tag_ff[0].zodd) begin
         if (tag_ff[0].fz >= tag_ff[0].fx) c_br = c_bl + c_tr - c_tl;
         else c_tl = c_tr + c_bl - c_br;
      end else begin
         if ({1'b0, tag_ff[0].fx} + {1'b0, tag_ff[0].fz} < 9'd256) c_tr = c_tl + c_br - c_bl;
         else c_bl = c_tl + c_br - c_tr;
      end
      dx_in = $signed({1'b0, rd_a1_ff}) - $signed({1'b0, rd_a0_ff});
      dz_in = $signed({1'b0, rd_b0_ff}) - $signed({1'b0, rd_a0_ff});
   end

   always_ff @(posedge clock) begin
      bl_ff <= c_bl;
      br_ff <= c_br;
      tl_ff <= c_tl;
      tr_ff <= c_tr;
      dx_ff <= dx_in;
      dz_ff <= dz_in;
   end

   // blend along x, scale the differences
   logic [8:0]         wx, wz;
   logic signed [26:0] top_ff, bot_ff;
   logic signed [33:0] a_ff, b_ff;

   assign wx = 9'd256 - {1'b0, tag_ff[1].fx};
   assign wz = 9'd256 - {1'b0, tag_ff[2].fz};

   always_ff @(posedge clock) begin
      top_ff <= 27'(tl_ff) * 27'($signed({1'b0, wx})) +
                27'(tr_ff) * 27'($signed({1'b0, tag_ff[1].fx}));
      bot_ff <= 27'(bl_ff) * 27'($signed({1'b0, wx})) +
                27'(br_ff) * 27'($signed({1'b0, tag_ff[1].fx}));
      a_ff   <= 34'(dx_ff) * 34'($signed({1'b0, height_scale_ff}));
      b_ff   <= 34'(dz_ff) * 34'($signed({1'b0, height_scale_ff}));
   end

   // blend along z; magnitudes, halved when too large
   logic [32:0]        am_full, bm_full;
   logic               halve;
   logic signed [35:0] t_ff;
   logic [30:0]        am_ff, bm_ff;
   logic [15:0]        dm_ff;
   logic               an_ff, bn_ff;

   always_comb begin
      am_full = a_ff[33] ? 33'(-a_ff) : 33'(a_ff);
      bm_full = b_ff[33] ? 33'(-b_ff) : 33'(b_ff);
      halve   = am_full[31] || bm_full[31];
   end

   always_ff @(posedge clock) begin
      t_ff  <= 36'(bot_ff) * 36'($signed({1'b0, wz})) +
               36'(top_ff) * 36'($signed({1'b0, tag_ff[2].fz})) + 36'sd128;
      am_ff <= halve ? am_full[31:1] : am_full[30:0];
      bm_ff <= halve ? bm_full[31:1] : bm_full[30:0];
      dm_ff <= halve ? {1'b0, hmap_pkg::SCALE_DEN[15:1]} : hmap_pkg::SCALE_DEN;
      an_ff <= a_ff[33];
      bn_ff <= b_ff[33];
   end

   // squares
   logic [61:0] asq_ff, bsq_ff;
   logic [31:0] dsq_ff;
   logic [30:0] am5_ff, bm5_ff;
   logic [15:0] dm5_ff;
   logic        an5_ff, bn5_ff;

   always_ff @(posedge clock) begin
      asq_ff <= am_ff * am_ff;
      bsq_ff <= bm_ff * bm_ff;
      dsq_ff <= dm_ff * dm_ff;
      am5_ff <= am_ff;
      bm5_ff <= bm_ff;
      dm5_ff <= dm_ff;
      an5_ff <= an_ff;
      bn5_ff <= bn_ff;
   end

   // square root, one result bit per stage
   sq_type sq_ff [0:hmap_pkg::SQRT_STAGES];
   sq_type sq_in [0:hmap_pkg::SQRT_STAGES];

   always_comb begin
      sq_in[0]      = '0;
      sq_in[0].rem  = SQ_W'(asq_ff) + SQ_W'(bsq_ff) + SQ_W'(dsq_ff);
      sq_in[0].am   = am5_ff;
      sq_in[0].bm   = bm5_ff;
      sq_in[0].dm   = dm5_ff;
      sq_in[0].an   = an5_ff;
      sq_in[0].bn   = bn5_ff;
   end

   for (genvar k = 1; k <= hmap_pkg::SQRT_STAGES; k++) begin : g_sqrt
      localparam int Bit = hmap_pkg::SQRT_STAGES - k;
      logic [SQ_W-1:0] trial;
      always_comb begin
         trial    = ({{RT_W{1'b0}}, sq_ff[k-1].root} << (Bit + 1)) +
                    ({{(SQ_W-1){1'b0}}, 1'b1} << (2 * Bit));
         sq_in[k] = sq_ff[k-1];
         if (sq_ff[k-1].rem >= trial) begin
            sq_in[k].rem  = sq_ff[k-1].rem - trial;
            sq_in[k].root = sq_ff[k-1].root | ({{(RT_W-1){1'b0}}, 1'b1} << Bit);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= hmap_pkg::SQRT_STAGES; k++) begin
         sq_ff[k] <= sq_in[k];
      end
   end

   // rounded division of each magnitude by the length, one quotient bit per stage
   dv_type dv_ff [0:hmap_pkg::DIV_STAGES];
   dv_type dv_in [0:hmap_pkg::DIV_STAGES];
   sq_type sq_last;

   always_comb begin
      sq_last      = sq_ff[hmap_pkg::SQRT_STAGES];
      dv_in[0]     = '0;
      dv_in[0].len = sq_last.root;
      dv_in[0].rx  = (DR_W'(sq_last.am) << hmap_pkg::NORM_FRAC) + DR_W'(sq_last.root >> 1);
      dv_in[0].ry  = (DR_W'(sq_last.dm) << hmap_pkg::NORM_FRAC) + DR_W'(sq_last.root >> 1);
      dv_in[0].rz  = (DR_W'(sq_last.bm) << hmap_pkg::NORM_FRAC) + DR_W'(sq_last.root >> 1);
      dv_in[0].an  = sq_last.an;
      dv_in[0].bn  = sq_last.bn;
   end

   for (genvar k = 1; k <= hmap_pkg::DIV_STAGES; k++) begin : g_div
      localparam int Bit = hmap_pkg::DIV_STAGES - k;
      logic [DR_W-1:0] dsh;
      logic [DQ_W-1:0] qbit;
      always_comb begin
         dsh      = DR_W'(dv_ff[k-1].len) << Bit;
         qbit     = {{(DQ_W-1){1'b0}}, 1'b1} << Bit;
         dv_in[k] = dv_ff[k-1];
         if (dv_ff[k-1].rx >= dsh) begin
            dv_in[k].rx = dv_ff[k-1].rx - dsh;
            dv_in[k].qx = dv_ff[k-1].qx | qbit;
         end
         if (dv_ff[k-1].ry >= dsh) begin
            dv_in[k].ry = dv_ff[k-1].ry - dsh;
            dv_in[k].qy = dv_ff[k-1].qy | qbit;
         end
         if (dv_ff[k-1].rz >= dsh) begin
            dv_in[k].rz = dv_ff[k-1].rz - dsh;
            dv_in[k].qz = dv_ff[k-1].qz | qbit;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= hmap_pkg::DIV_STAGES; k++) begin
         dv_ff[k] <= dv_in[k];
      end
   end

   // item tags travel alongside the data; height joins after the z blend
   tag_type tags_in [0:TAGS-1];

   always_comb begin
      tags_in[0] = tag_in;
      for (int k = 1; k < TAGS; k++) begin
         tags_in[k] = tag_ff[k-1];
      end
      tags_in[4].height = t_ff[33:8];
      if (reset) begin
         for (int k = 0; k < TAGS; k++) begin
            tags_in[k].valid = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < TAGS; k++) begin
         tag_ff[k] <= tags_in[k];
      end
   end

   // result assembly
   tag_type            tag_last;
   dv_type             dv_last;
   logic               rsp_valid_ff, rsp_valid_in, rsp_outside_ff, rsp_outside_in;
   logic signed [25:0] rsp_height_ff, rsp_height_in;
   logic signed [15:0] nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;

   always_comb begin
      tag_last       = tag_ff[TAGS-1];
      dv_last        = dv_ff[hmap_pkg::DIV_STAGES];
      rsp_valid_in   = tag_last.valid;
      rsp_outside_in = tag_last.outside;
      rsp_height_in  = '0;
      nx_in          = '0;
      ny_in          = '0;
      nz_in          = '0;
      if (!tag_last.is_norm) begin
         if (!tag_last.outside) rsp_height_in = $signed(tag_last.height);
      end else if (tag_last.outside) begin
         ny_in = $signed(hmap_pkg::NORM_ONE);
      end else begin
         nx_in = dv_last.an ? $signed(16'(dv_last.qx)) : $signed(16'd0 - 16'(dv_last.qx));
         ny_in = $signed(16'(dv_last.qy));
         nz_in = dv_last.bn ? $signed(16'(dv_last.qz)) : $signed(16'd0 - 16'(dv_last.qz));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      rsp_outside_ff <= rsp_outside_in;
      rsp_height_ff  <= rsp_height_in;
      nx_ff          <= nx_in;
      ny_ff          <= ny_in;
      nz_ff          <= nz_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_outside  = rsp_outside_ff;
   assign rsp_height   = rsp_height_ff;
   assign rsp_normal_x = nx_ff;
   assign rsp_normal_y = ny_ff;
   assign rsp_normal_z = nz_ff;

endmodule

### hw/rtl/hmap_checker.sv
// port-level checks of the heightmap sampler and their bind
`timescale 1ns / 1ps

module hmap_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_type,
   input logic signed [17:0] req_coord_x,
   input logic               rsp_valid,
   input logic signed [25:0] rsp_height,
   input logic signed [15:0] rsp_normal_x,
   input logic signed [15:0] rsp_normal_y,
   input logic signed [15:0] rsp_normal_z,
   input logic               rsp_outside
);

   localparam int LW = $clog2(hmap_pkg::LATENCY + 1);

   // cycles since reset, so that look-backs never reach into reset
   logic [LW-1:0] settled_ff, settled_in;
   logic          full;

   assign full       = settled_ff == LW'(hmap_pkg::LATENCY);
   assign settled_in = full ? settled_ff : settled_ff + LW'(1);

   always_ff @(posedge clock) begin
      if (reset) settled_ff <= '0;
      else settled_ff <= settled_in;
   end

   // every query gives exactly one result, and no result comes without a query
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      full |-> rsp_valid == $past(start && !busy &&
         (req_type == hmap_pkg::REQ_HEIGHT || req_type == hmap_pkg::REQ_NORMAL),
         hmap_pkg::LATENCY))
      else $error("result count does not follow query transfers");

   // a height query left of the map comes back outside
   a_left_outside: assert property (@(posedge clock) disable iff (reset)
      full && $past(start && !busy && req_type == hmap_pkg::REQ_HEIGHT && req_coord_x[17],
         hmap_pkg::LATENCY) |-> rsp_valid && rsp_outside)
      else $error("height query left of map not flagged outside");

   // outside results carry zero height and a straight-up or empty normal
   a_outside_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside |-> rsp_height == 26'sd0 && rsp_normal_x == 16'sd0 &&
         rsp_normal_z == 16'sd0 &&
         (rsp_normal_y == 16'sd0 || rsp_normal_y == $signed(hmap_pkg::NORM_ONE)))
      else $error("outside result has unexpected fields");

   // a tilted normal never points down and carries no height
   a_normal_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_normal_x != 16'sd0 || rsp_normal_z != 16'sd0) |->
         rsp_normal_y >= 16'sd0 && rsp_height == 26'sd0 && !rsp_outside)
      else $error("normal result mixes in height or points down");

endmodule

bind heightmap_sampler_top hmap_checker u_hmap_checker (.*);

### tb/tb_top.sv
// self-checking testbench for the heightmap sampler
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 4000;

   // expected result of one query
   typedef struct {
      logic [25:0] height;
      logic [15:0] nx;
      logic [15:0] ny;
      logic [15:0] nz;
      logic        outside;
   } sample_result_type;

   // terrain predictor and store of expected query results
   class hmap_scoreboard;
      bit [15:0]         terrain [0:65535];
      int unsigned       width_reg = 256;
      int unsigned       height_reg = 256;
      longint            scale_reg = 256;
      sample_result_type awaited[$];
      int                errors = 0;

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            hmap_pkg::CSR_MAP_WIDTH:    width_reg = val[8:0];
            hmap_pkg::CSR_MAP_HEIGHT:   height_reg = val[8:0];
            hmap_pkg::CSR_HEIGHT_SCALE: scale_reg = val;
            default: ;
         endcase
      endfunction

      function int unsigned cols();
         return width_reg < 2 ? 2 : (width_reg > 256 ? 256 : width_reg);
      endfunction

      function int unsigned rows();
         return height_reg < 2 ? 2 : (height_reg > 256 ? 256 : height_reg);
      endfunction

      function longint fetch(longint x, longint z);
         return longint'(terrain[(x + z * 256) % 65536]);
      endfunction

      function longint unsigned root(longint unsigned s);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > s) b = b >> 2;
         while (b != 0) begin
            if (s >= res + b) begin
               s = s - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function logic [15:0] unit_comp(bit neg, longint unsigned mag, longint unsigned len);
         longint unsigned q;
         q = (16384 * mag + len / 2) / len;
         return neg ? 16'(-q) : 16'(q);
      endfunction

      // predict the effect of one accepted request
      function void note_input(logic [1:0] kind, logic [7:0] col, logic [7:0] row,
                               logic [15:0] smp, logic signed [17:0] x_in,
                               logic signed [17:0] z_in);
         sample_result_type r;
         longint w, h, cx, cz, x, z, fx, fz, x1, z1, bl, br, tl, tr, top, bot, t;
         longint xn, zn, s, a, b;
         longint unsigned am, bm, dm, len;
         bit an, bn;
         w = cols();
         h = rows();
         cx = x_in;
         cz = z_in;
         r = '{default: '0};
         if (kind == hmap_pkg::REQ_WRITE) begin
            if (col < w && row < h) terrain[col + (h - 1 - row) * 256] = smp;
            return;
         end
         if (kind == REQ_UNUSED) return;
         if (kind == hmap_pkg::REQ_HEIGHT) begin
            if (cx < 0 || cz < 0 || cx >= w * 256 || cz >= h * 256) begin
               r.outside = 1'b1;
            end else begin
               x = cx >>> 8;
               z = cz >>> 8;
               fx = cx & 255;
               fz = cz & 255;
               x1 = (x + 1 < w) ? x + 1 : w - 1;
               z1 = (z + 1 < h) ? z + 1 : h - 1;
               bl = fetch(x, z);
               br = fetch(x1, z);
               tl = fetch(x, z1);
               tr = fetch(x1, z1);
               // rebuild the corner away from the triangle holding the point
               if (z[0]) begin
                  if (fz >= fx) br = bl + (tr - tl);
                  else tl = tr + (bl - br);
               end else begin
                  if (fx + fz < 256) tr = tl + (br - bl);
                  else bl = tl + (br - tr);
               end
               top = tl * (256 - fx) + tr * fx;
               bot = bl * (256 - fx) + br * fx;
               t = bot * (256 - fz) + top * fz + 128;
               r.height = 26'(t >>> 8);
            end
         end else begin
            x = cx / 256;
            z = cz / 256;
            if (x < 0 || z < 0 || x >= w || z >= h) begin
               r.ny = hmap_pkg::NORM_ONE;
               r.outside = 1'b1;
            end else begin
               xn = (x < w - 1) ? x + 1 : x - 1;
               zn = (z < h - 1) ? z + 1 : z - 1;
               s = fetch(x, z);
               a = (fetch(xn, z) - s) * scale_reg;
               b = (fetch(x, zn) - s) * scale_reg;
               an = a < 0;
               bn = b < 0;
               am = an ? -a : a;
               bm = bn ? -b : b;
               dm = hmap_pkg::SCALE_DEN;
               // keep the squared length inside 64 bits
               if (am >= 64'd1 << 31 || bm >= 64'd1 << 31) begin
                  am = am >> 1;
                  bm = bm >> 1;
                  dm = dm >> 1;
               end
               len = root(am * am + bm * bm + dm * dm);
               r.nx = unit_comp(!an && am != 0, am, len);
               r.ny = unit_comp(1'b0, dm, len);
               r.nz = unit_comp(!bn && bm != 0, bm, len);
            end
         end
         awaited.push_back(r);
      endfunction

      // compare one result transfer with the oldest prediction
      function void check_result(logic [25:0] hgt, logic [15:0] nx, logic [15:0] ny,
                                 logic [15:0] nz, logic outs);
         sample_result_type e;
         if (awaited.size() == 0) begin
            $error("result transfer with no query outstanding");
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (hgt !== e.height) begin
            $error("height expected %0d got %0d", $signed(e.height), $signed(hgt));
            errors++;
         end
         if (nx !== e.nx) begin
            $error("normal_x expected %0d got %0d", $signed(e.nx), $signed(nx));
            errors++;
         end
         if (ny !== e.ny) begin
            $error("normal_y expected %0d got %0d", $signed(e.ny), $signed(ny));
            errors++;
         end
         if (nz !== e.nz) begin
            $error("normal_z expected %0d got %0d", $signed(e.nz), $signed(nz));
            errors++;
         end
         if (outs !== e.outside) begin
            $error("outside expected %0d got %0d", e.outside, outs);
            errors++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_type = hmap_pkg::REQ_WRITE;
   logic [7:0]         req_col = '0;
   logic [7:0]         req_row = '0;
   logic [15:0]        req_sample = '0;
   logic signed [17:0] req_coord_x = '0;
   logic signed [17:0] req_coord_z = '0;
   logic               rsp_valid;
   logic signed [25:0] rsp_height;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic               rsp_outside;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   hmap_scoreboard sb = new();
   int idle_cycles = 0;
   int calm_left = 0;

   heightmap_sampler_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_col(req_col), .req_row(req_row),
      .req_sample(req_sample), .req_coord_x(req_coord_x), .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid), .rsp_height(rsp_height), .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y), .rsp_normal_z(rsp_normal_z),
      .rsp_outside(rsp_outside), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // monitor of every transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_input(req_type, req_col, req_row, req_sample, req_coord_x, req_coord_z);
         if (csr_valid && csr_ready) sb.set_reg(csr_index, csr_wdata);
         if (rsp_valid)
            sb.check_result(rsp_height, rsp_normal_x, rsp_normal_y, rsp_normal_z,
                            rsp_outside);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // one request transfer, with a random gap before it
   task automatic send_req(logic [1:0] kind, logic [7:0] col, logic [7:0] row,
                           logic [15:0] smp, logic signed [17:0] cx,
                           logic signed [17:0] cz);
      int gap;
      if (calm_left > 0) begin
         gap = 0;
         calm_left--;
      end else begin
         gap = $urandom_range(0, 10);
         if ($urandom_range(0, 40) == 0) calm_left = $urandom_range(10, 50);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_type <= kind;
      req_col <= col;
      req_row <= row;
      req_sample <= smp;
      req_coord_x <= cx;
      req_coord_z <= cz;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic query(logic [1:0] kind, int cx, int cz);
      send_req(kind, 8'($urandom), 8'($urandom), 16'($urandom), 18'(cx), 18'(cz));
   endtask

   // hold requests until every query has returned and writes have settled
   task automatic settle();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (hmap_pkg::LATENCY + 4) @(posedge clock);
   endtask

   task automatic configure(int w, int h, int scale);
      settle();
      csr_valid <= 1'b1;
      csr_index <= hmap_pkg::CSR_MAP_WIDTH;
      csr_wdata <= 16'(w);
      do @(posedge clock); while (!csr_ready);
      csr_index <= hmap_pkg::CSR_MAP_HEIGHT;
      csr_wdata <= 16'(h);
      do @(posedge clock); while (!csr_ready);
      csr_index <= hmap_pkg::CSR_HEIGHT_SCALE;
      csr_wdata <= 16'(scale);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // write every sample of the map in use so no query reads stale data
   task automatic fill_map();
      for (int r = 0; r < sb.rows(); r++)
         for (int c = 0; c < sb.cols(); c++)
            send_req(hmap_pkg::REQ_WRITE, 8'(c), 8'(r), pick_sample(),
                     18'($urandom), 18'($urandom));
   endtask

   function automatic int pick_coord(int span);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 600) - 300;
         1: return span + $urandom_range(0, 600) - 300;
         2: return int'($signed(18'($urandom)));
         default: return $urandom_range(0, span - 1);
      endcase
   endfunction

   task automatic random_traffic(int count, bit hold_mid);
      int k;
      for (int i = 0; i < count; i++) begin
         if (hold_mid && i == count / 2) settle();
         k = $urandom_range(0, 19);
         if (k < 4)
            send_req(hmap_pkg::REQ_WRITE, 8'($urandom_range(0, sb.cols() - 1)),
                     8'($urandom_range(0, sb.rows() - 1)), pick_sample(),
                     18'($urandom), 18'($urandom));
         else if (k == 4)
            send_req(hmap_pkg::REQ_WRITE, 8'($urandom), 8'($urandom), 16'($urandom),
                     18'($urandom), 18'($urandom));
         else if (k == 5)
            query(REQ_UNUSED, int'($urandom), int'($urandom));
         else if (k < 13)
            query(hmap_pkg::REQ_HEIGHT, pick_coord(sb.cols() * 256),
                  pick_coord(sb.rows() * 256));
         else
            query(hmap_pkg::REQ_NORMAL, pick_coord(sb.cols() * 256),
                  pick_coord(sb.rows() * 256));
      end
   endtask

   // stimulus
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed corners on a 4 x 4 map with steep slopes
      configure(4, 4, 65535);
      fill_map();
      query(hmap_pkg::REQ_HEIGHT, 0, 0);
      query(hmap_pkg::REQ_HEIGHT, 1023, 1023);
      query(hmap_pkg::REQ_HEIGHT, -1, 10);
      query(hmap_pkg::REQ_HEIGHT, 10, -1);
      query(hmap_pkg::REQ_HEIGHT, 1024, 10);
      query(hmap_pkg::REQ_HEIGHT, 10, 1024);
      query(hmap_pkg::REQ_HEIGHT, 131071, 131071);
      query(hmap_pkg::REQ_HEIGHT, -131072, -131072);
      query(hmap_pkg::REQ_HEIGHT, 20, 256 + 200);
      query(hmap_pkg::REQ_HEIGHT, 200, 256 + 20);
      query(hmap_pkg::REQ_HEIGHT, 20, 30);
      query(hmap_pkg::REQ_HEIGHT, 200, 230);
      query(hmap_pkg::REQ_HEIGHT, 128, 128);
      query(hmap_pkg::REQ_NORMAL, -255, -255);
      query(hmap_pkg::REQ_NORMAL, -256, 10);
      query(hmap_pkg::REQ_NORMAL, 10, -256);
      query(hmap_pkg::REQ_NORMAL, 1023, 1023);
      query(hmap_pkg::REQ_NORMAL, 1024, 0);
      query(hmap_pkg::REQ_NORMAL, 0, 1024);
      query(hmap_pkg::REQ_NORMAL, 300, 600);
      query(hmap_pkg::REQ_NORMAL, -131072, 131071);
      query(REQ_UNUSED, 0, 0);
      send_req(hmap_pkg::REQ_WRITE, 8'd255, 8'd255, 16'hFFFF, 18'sd0, 18'sd0);
      random_traffic(40, 1'b1);

      // clamped sizes and extreme scales
      configure(1, 3, 0);
      fill_map();
      random_traffic(30, 1'b0);
      configure(300, 0, 1000);
      fill_map();
      random_traffic(30, 1'b0);
      configure(0, 511, 65535);
      fill_map();
      random_traffic(30, 1'b0);

      // random small maps
      for (int p = 0; p < 2; p++) begin
         configure($urandom_range(2, 12), $urandom_range(2, 12),
                   ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535));
         fill_map();
         random_traffic(30, p == 1);
      end

      settle();
      if (sb.pending() != 0) begin
         $error("%0d query results never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

### files.f
hw/rtl/hmap_pkg.sv
hw/rtl/heightmap_sampler_top.sv
hw/rtl/hmap_checker.sv
tb/tb_top.sv
